// ===== rtl/core/xoroshiro128p_bounded_draw_defines.svh =====
// assertion macros shared by the draw block
`ifndef XOROSHIRO128P_BOUNDED_DRAW_DEFINES_SVH
`define XOROSHIRO128P_BOUNDED_DRAW_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define XBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the trigger
`define XBD_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/xbd_pkg.sv =====
package xbd_pkg;

  // rotation and shift amounts of the generator step
  localparam int unsigned ROT_A   = 24;
  localparam int unsigned ROT_B   = 37;
  localparam int unsigned SHIFT_C = 16;

  // reset value of the second state word
  localparam logic [63:0] WORD_B_RESET = 64'h82A2_B175_229D_6A5B;

  // input command codes
  typedef enum logic [1:0] {
    CMD_SEED = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_RAW  = 2'd2
  } cmd_e_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_SEEDED = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input transfer
    logic step;      // advance the generator once
    logic out_load;  // write the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e_t cmd;
    logic   bound_zero;
    logic   draw_ok;
  } dp_stat_t;

endpackage

// ===== rtl/core/xbd_datapath.sv =====
module xbd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  xbd_pkg::ctrl_cmd_t  ctrl,
  output xbd_pkg::dp_stat_t   stat,
  input  logic [1:0]          in_command,
  input  logic [63:0]         in_seed_first,
  input  logic [63:0]         in_seed_second,
  input  logic [31:0]         in_bound,
  output logic [63:0]         out_value,
  output logic [1:0]          out_status
);
  import xbd_pkg::*;

  logic [63:0] word_a_r, word_a_nxt;
  logic [63:0] word_b_r, word_b_nxt;
  cmd_e_t      cmd_r;
  logic [31:0] bound_r;
  logic [31:0] mask_r;
  logic [31:0] mask_nxt;
  logic [63:0] sum;
  logic [63:0] t;
  logic [31:0] masked;
  logic [63:0] value_r, value_nxt;
  status_t     status_r, status_nxt;

  // cover mask: every bit below the top set bit of bound minus one
  always_comb begin
    mask_nxt = in_bound - 32'd1;
    mask_nxt = mask_nxt | (mask_nxt >> 1);
    mask_nxt = mask_nxt | (mask_nxt >> 2);
    mask_nxt = mask_nxt | (mask_nxt >> 4);
    mask_nxt = mask_nxt | (mask_nxt >> 8);
    mask_nxt = mask_nxt | (mask_nxt >> 16);
  end

  // generator step
  assign sum    = word_a_r + word_b_r;
  assign t      = word_a_r ^ word_b_r;
  assign masked = sum[31:0] & mask_r;

  // state words: seed on capture, advance on step
  always_comb begin
    word_a_nxt = word_a_r;
    word_b_nxt = word_b_r;
    if (ctrl.capture && (in_command == CMD_SEED)) begin
      word_a_nxt = in_seed_first;
      word_b_nxt = in_seed_second;
    end else if (ctrl.step) begin
      word_a_nxt = {word_a_r[63-ROT_A:0], word_a_r[63:64-ROT_A]} ^ t ^ (t << SHIFT_C);
      word_b_nxt = {t[63-ROT_B:0], t[63:64-ROT_B]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_a_r <= 64'd0;
      word_b_r <= WORD_B_RESET;
    end else begin
      word_a_r <= word_a_nxt;
      word_b_r <= word_b_nxt;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r   <= cmd_e_t'(in_command);
      bound_r <= in_bound;
      mask_r  <= mask_nxt;
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.bound_zero = (bound_r == 32'd0);
  assign stat.draw_ok    = (masked < bound_r);

  // result selection
  always_comb begin
    value_nxt  = 64'd0;
    status_nxt = ST_REJECT;
    case (cmd_r)
      CMD_SEED: status_nxt = ST_SEEDED;
      CMD_RAW: begin
        value_nxt  = sum;
        status_nxt = ST_VALID;
      end
      CMD_DRAW: begin
        if (bound_r != 32'd0) begin
          value_nxt  = {32'd0, masked};
          status_nxt = ST_VALID;
        end
      end
      default: status_nxt = ST_REJECT;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

// ===== rtl/core/xbd_ctrl.sv =====
`include "xoroshiro128p_bounded_draw_defines.svh"

module xbd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  xbd_pkg::dp_stat_t   stat,
  output xbd_pkg::ctrl_cmd_t  ctrl
);
  import xbd_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register may be written when empty or being drained
  assign out_free = !out_valid_r || out_tready;

  // outputs
  always_comb begin
    in_tready     = 1'b0;
    ctrl.capture  = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        ctrl.capture = in_tvalid;
      end
      S_EXEC: begin
        if (out_free) begin
          case (stat.cmd)
            CMD_RAW: begin
              ctrl.step     = 1'b1;
              ctrl.out_load = 1'b1;
            end
            CMD_DRAW: begin
              if (stat.bound_zero) begin
                ctrl.out_load = 1'b1;
              end else begin
                ctrl.step     = 1'b1;
                ctrl.out_load = stat.draw_ok;
              end
            end
            default: ctrl.out_load = 1'b1;
          endcase
        end
      end
      default: in_tready = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: if (ctrl.out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // checks
  `XBD_ASSERT(a_no_overwrite, !(ctrl.out_load && out_valid_r && !out_tready), "result overwritten")
  `XBD_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, state_r == S_EXEC, "accept not executed")
  `XBD_ASSERT_NEXT(a_load_valid, ctrl.out_load, out_valid_r, "loaded result not shown")
  `XBD_ASSERT(a_capture_idle, !(ctrl.capture && (ctrl.step || ctrl.out_load)), "capture during exec")

endmodule

// ===== rtl/core/xoroshiro128p_bounded_draw.sv =====
// xoroshiro128+ generator with bounded integer draws by mask and reject.
// Input channel (in_*): one transfer per command. in_tuser carries the command
// (seed load, bounded draw, raw draw); in_tdata carries seed words and bound.
// Result channel (out_*): exactly one transfer per command. out_tdata is the
// drawn value (zero for seed and rejected commands), out_tuser the status.
// Timing: a command is taken in the idle state, then executes with one generator
// step per cycle while the output register is free. Seed and rejected commands
// write their result without a step, a raw draw with its step; a bounded draw
// steps until the masked value falls below the bound, each step passing with a
// chance over one half. The result is in the output register the cycle after the last step.
// The rate is set by the single generator step unit and by one command in
// flight at a time.
// Reset (rst_n low, synchronous): state word a clears, word b takes its fixed
// reset value, the output register empties.
// Receiver stall: a finished result waits in the output register; a new
// command is still accepted, and execution holds before writing its result
// until the waiting one has been transferred.
module xoroshiro128p_bounded_draw (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // seed_first[63:0], seed_second[127:64], bound[159:128]
  input  logic [1:0]   in_tuser,   // command[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // value[63:0]
  output logic [1:0]   out_tuser   // status[1:0]
);
  import xbd_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  xbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  xbd_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_command     (in_tuser),
    .in_seed_first  (in_tdata[63:0]),
    .in_seed_second (in_tdata[127:64]),
    .in_bound       (in_tdata[159:128]),
    .out_value      (out_tdata),
    .out_status     (out_tuser)
  );

endmodule
